@@ src/sida_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared package
// Widths, character codes, reciprocal constant and sequencer states used by
// the converter, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned LenW      = 4;
  localparam int unsigned CharW     = 7;
  localparam int unsigned PosW      = 4;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CountW    = 4;   // holds 0..MaxDigits
  localparam int unsigned IdxW      = $clog2(MaxDigits);

  // floor(x / 10) == (x * Recip10) >> Recip10Shift for every 32-bit x
  localparam logic [ValueW-1:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned       Recip10Shift = 35;
  localparam int unsigned       QuotW        = 2 * ValueW - Recip10Shift;

  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharMinus = 7'd45;
  localparam logic [CharW-1:0] CharNul   = 7'd0;

  localparam logic [LenW-1:0] MinLen = 4'd2;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StRem,
    StCheck,
    StSign,
    StDigit,
    StTerm
  } state_e;

endpackage

@@ src/sida_in_if.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: input channel
// Valid/ready channel carrying the value and the buffer length.
// ----------------------------------------------------------------------------
interface sida_in_if
  import sida_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic        [LenW-1:0]   buffer_len;

  modport source (output valid, value, buffer_len, input ready);
  modport sink   (input valid, value, buffer_len, output ready);
endinterface

@@ src/sida_out_if.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: output channel
// Valid/ready channel carrying one character, its position and a last flag.
// ----------------------------------------------------------------------------
interface sida_out_if
  import sida_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic [PosW-1:0]  position;
  logic             last;

  modport source (output valid, character, position, last, input ready);
  modport sink   (input valid, character, position, last, output ready);
endinterface

@@ src/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter
// Turns a signed 32-bit value into sign, decimal digits and a terminator.
// ----------------------------------------------------------------------------
// One beat in gives up to twelve character beats out, in buffer order. A
// single reciprocal multiplier peels off one decimal digit at a time
// (multiply, then quotient and remainder); after the last digit a fit check
// runs, then the block emits one character a cycle while the output is taken.
// The input is not ready until the last character of the item has been
// loaded into the output register, or until the fit check ends for an
// item that writes no character.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sida_in_if.sink           in_i,
  sida_out_if.source        out_o
);

  state_e state_q, state_d;

  logic              neg_q;
  logic [LenW-1:0]   blen_q;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [2*ValueW-1:0] prod_q;
  logic [CountW-1:0] ndig_q, ndig_d;
  logic [IdxW-1:0]   didx_q, didx_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [DigitW-1:0] digit_q [MaxDigits];

  logic             out_valid_q, out_last_q;
  logic [CharW-1:0] out_char_q;
  logic [PosW-1:0]  out_pos_q;

  logic              accept;
  logic              load;
  logic [QuotW-1:0]  quot;
  logic [ValueW-1:0] quot_x10;
  logic [ValueW-1:0] rem;
  logic              fits;
  logic              digit_we;

  // beat loaders
  logic             ld_en;
  logic [CharW-1:0] ld_char;
  logic [PosW-1:0]  ld_pos;
  logic             ld_last;

  assign accept = in_i.valid && in_i.ready;
  assign load   = !out_valid_q || out_o.ready;

  // quotient and remainder of the shared divide-by-ten step
  assign quot     = prod_q[2*ValueW-1:Recip10Shift];
  assign quot_x10 = ValueW'({quot, 3'b000}) + ValueW'({quot, 1'b0});
  assign rem      = mag_q - quot_x10;

  // sign + digits + terminator must fit in the buffer
  assign fits = ({{(CountW-1){1'b0}}, neg_q} + ndig_q) < CountW'(blen_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StMul;
      StMul:   state_d = StRem;
      StRem:   state_d = (quot == '0) ? StCheck : StMul;
      StCheck: begin
        if (blen_q < MinLen) state_d = StIdle;
        else if (fits) state_d = neg_q ? StSign : StDigit;
        else state_d = neg_q ? StSign : StIdle;
      end
      StSign:  if (load) state_d = fits ? StDigit : StIdle;
      StDigit: if (load && didx_q == '0) state_d = StTerm;
      StTerm:  if (load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath controls and beat contents
  always_comb begin
    mag_d    = mag_q;
    ndig_d   = ndig_q;
    didx_d   = didx_q;
    pos_d    = pos_q;
    digit_we = 1'b0;
    ld_en    = 1'b0;
    ld_char  = CharNul;
    ld_pos   = pos_q;
    ld_last  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          mag_d  = in_i.value[ValueW-1] ? ('0 - ValueW'(in_i.value))
                                        : ValueW'(in_i.value);
          ndig_d = '0;
        end
      end
      StMul: ;
      StRem: begin
        digit_we = 1'b1;
        mag_d    = ValueW'(quot);
        ndig_d   = ndig_q + CountW'(1);
      end
      StCheck: begin
        didx_d = IdxW'(ndig_q - CountW'(1));
        pos_d  = PosW'(neg_q);
      end
      StSign: begin
        ld_en   = load;
        ld_char = CharMinus;
        ld_pos  = '0;
        ld_last = !fits;
      end
      StDigit: begin
        ld_en   = load;
        ld_char = CharZero + CharW'(digit_q[didx_q]);
        if (load) begin
          pos_d = pos_q + PosW'(1);
          if (didx_q != '0) didx_d = didx_q - IdxW'(1);
        end
      end
      StTerm: begin
        ld_en   = load;
        ld_char = CharNul;
        ld_last = 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_en) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload: hold item, run the multiplier, store digits, load beats
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q  <= in_i.value[ValueW-1];
      blen_q <= in_i.buffer_len;
    end
    if (state_q == StMul) prod_q <= mag_q * Recip10;
    if (digit_we) digit_q[ndig_q[IdxW-1:0]] <= rem[DigitW-1:0];
    mag_q  <= mag_d;
    ndig_q <= ndig_d;
    didx_q <= didx_d;
    pos_q  <= pos_d;
    if (ld_en) begin
      out_char_q <= ld_char;
      out_pos_q  <= ld_pos;
      out_last_q <= ld_last;
    end
  end

  assign in_i.ready      = (state_q == StIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.position  = out_pos_q;
  assign out_o.last      = out_last_q;

endmodule

@@ src/sida_checker.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: port checker
// Watches the converter's channels and flags beats that break its rules.
// ----------------------------------------------------------------------------
module sida_checker
  import sida_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] out_character_i,
  input logic [PosW-1:0]  out_position_i,
  input logic             out_last_i
);

  // hold a stalled beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_character_i)
      && $stable(out_position_i) && $stable(out_last_i))
    else $error("stalled output beat changed");

  // busy once an item has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after accepting an item");

  // minus sign only at the start of the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_character_i == CharMinus |-> out_position_i == '0)
    else $error("minus sign away from position zero");

  // terminator closes the item, and only the terminator or a lone sign does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_character_i == CharNul))
      || (out_last_i && out_character_i == CharMinus))
    else $error("last flag does not match the terminator");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_character_i(out_o.character),
  .out_position_i (out_o.position),
  .out_last_i     (out_o.last)
);

@@ tb/sv/tb_signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: self-checking testbench
// Drives signed 32-bit values with buffer lengths into the converter and
// checks every character beat against a local text predictor. The run covers
// a directed set of edge values, then randomised values with mostly fitting
// lengths, with random idling on both channels and one idle-free stretch.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
  import sida_pkg::*;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic        [LenW-1:0]   buffer_len;
  } int_item_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic [PosW-1:0]  position;
    logic             last;
  } char_beat_t;

  localparam int unsigned IdlePercent  = 26;
  localparam int unsigned SettleCycles = 60;

  logic clk_i = 1'b0;
  logic rst_ni;

  sida_in_if  in_ch ();
  sida_out_if out_ch ();

  int_item_t  pending_ints[$];
  char_beat_t expected_chars[$];
  int         ints_sent;
  int         ints_taken;
  int         mismatches;
  bit         steady_traffic;

  signed_int_to_decimal_ascii dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Work out the characters written for one value and buffer length
  function automatic void predict_chars(input int_item_t it);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digits [MaxDigits];
    logic [PosW-1:0]   pos;
    logic              neg;
    int                ndig;
    neg  = it.value[ValueW-1];
    mag  = neg ? (32'd0 - it.value) : it.value;
    ndig = 0;
    if (it.buffer_len < MinLen) begin
      return;
    end
    // zero is always "0" plus terminator
    if (mag == 0) begin
      expected_chars.push_back(char_beat_t'{CharZero, 4'd0, 1'b0});
      expected_chars.push_back(char_beat_t'{CharNul, 4'd1, 1'b1});
      return;
    end
    while (mag != 0) begin
      digits[ndig] = mag % 10;
      mag          = mag / 10;
      ndig++;
    end
    pos = neg ? 4'd1 : 4'd0;
    // text too long: a negative value still leaves its sign behind
    if (pos + ndig >= it.buffer_len) begin
      if (neg) begin
        expected_chars.push_back(char_beat_t'{CharMinus, 4'd0, 1'b1});
      end
      return;
    end
    if (neg) begin
      expected_chars.push_back(char_beat_t'{CharMinus, 4'd0, 1'b0});
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      expected_chars.push_back(char_beat_t'{CharZero + digits[i], pos, 1'b0});
      pos++;
    end
    expected_chars.push_back(char_beat_t'{CharNul, pos, 1'b1});
  endfunction

  // Drive input beats at the falling edge, hold each until taken
  always @(negedge clk_i) begin : drive_ints
    int_item_t nxt;
    if (rst_ni) begin
      if (in_ch.valid && ints_taken != ints_sent) begin
        // hold the current beat
      end else if (pending_ints.size() != 0 &&
                   (steady_traffic || $urandom_range(99) >= IdlePercent)) begin
        nxt = pending_ints.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.value      <= nxt.value;
        in_ch.buffer_len <= nxt.buffer_len;
        ints_sent++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the character channel at random
  always @(negedge clk_i) begin : drive_ready
    out_ch.ready <= rst_ni && (steady_traffic || $urandom_range(99) >= IdlePercent);
  end

  // Check character beats first, then record newly taken input beats
  always @(posedge clk_i) begin : check_chars
    char_beat_t got;
    char_beat_t exp;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = char_beat_t'{out_ch.character, out_ch.position, out_ch.last};
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char beat char=%0d pos=%0d last=%0b",
                   $time, got.character, got.position, got.last);
          mismatches++;
        end else begin
          exp = expected_chars.pop_front();
          if (got.character !== exp.character || got.position !== exp.position ||
              got.last !== exp.last) begin
            $display({"%0t: char beat mismatch expected char=%0d pos=%0d last=%0b,",
                      " actual char=%0d pos=%0d last=%0b"},
                     $time, exp.character, exp.position, exp.last,
                     got.character, got.position, got.last);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_chars(int_item_t'{in_ch.value, in_ch.buffer_len});
        ints_taken++;
      end
    end
  end

  task automatic queue_int(input logic signed [ValueW-1:0] value,
                           input logic [LenW-1:0] buffer_len);
    pending_ints.push_back(int_item_t'{value, buffer_len});
  endtask

  // Mostly well-formed values of random digit count with a fitting length,
  // the rest boundary lengths, zero and raw noise
  task automatic queue_random_ints(input int count);
    int_item_t   it;
    int unsigned ndig;
    int unsigned need;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    int unsigned sel;
    longint      top;
    logic        neg;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      neg = $urandom_range(1);
      if (sel < 8) begin
        it.value      = $urandom;
        it.buffer_len = $urandom_range(15, 0);
      end else if (sel < 12) begin
        it.value      = 0;
        it.buffer_len = $urandom_range(15, 0);
      end else begin
        ndig = $urandom_range(MaxDigits, 1);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        top = longint'(lo) * 10 - 1;
        if (top > 64'd2147483647) begin
          top = neg ? 64'd2147483648 : 64'd2147483647;
        end
        hi       = top;
        mag      = $urandom_range(hi, lo);
        it.value = neg ? (32'd0 - mag) : mag;
        need     = neg + ndig + 1;
        sel      = $urandom_range(99);
        if (sel < 70) begin
          it.buffer_len = $urandom_range(15, need);
        end else if (sel < 85) begin
          it.buffer_len = need - 1;
        end else begin
          it.buffer_len = $urandom_range(15, 0);
        end
      end
      pending_ints.push_back(it);
    end
  endtask

  // Block until every queued beat is taken and every character has come
  task automatic wait_drained();
    while (pending_ints.size() != 0 || ints_taken != ints_sent ||
           expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    in_ch.buffer_len = '0;
    out_ch.ready     = 1'b0;
    ints_sent        = 0;
    ints_taken       = 0;
    mismatches       = 0;
    steady_traffic   = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: buffer too small, zero, extremes, exact fits and overflows
    queue_int(0, 4'd0);
    queue_int(0, 4'd1);
    queue_int(0, 4'd2);
    queue_int(0, 4'd15);
    queue_int(32'sh8000_0000, 4'd15);
    queue_int(32'sh8000_0000, 4'd12);
    queue_int(32'sh8000_0000, 4'd11);
    queue_int(32'sh7FFF_FFFF, 4'd15);
    queue_int(32'sh7FFF_FFFF, 4'd11);
    queue_int(32'sh7FFF_FFFF, 4'd10);
    queue_int(-1, 4'd2);
    queue_int(-1, 4'd3);
    queue_int(1, 4'd1);
    queue_int(1, 4'd2);
    queue_int(42, 4'd2);
    queue_int(-123456789, 4'd4);
    queue_int(123456789, 4'd15);
    queue_int(1000000000, 4'd11);
    queue_int(999999999, 4'd10);
    queue_int(-999999999, 4'd11);
    queue_int(-10, 4'd4);
    queue_int(32'sh5555_5555, 4'd14);
    queue_int(32'shAAAA_AAAA, 4'd13);
    queue_int(-7, 4'd1);

    // Pause the sender until the directed text has fully drained
    wait_drained();

    queue_random_ints(38);
    wait_drained();
    steady_traffic = 1'b1;
    queue_random_ints(32);
    wait_drained();
    steady_traffic = 1'b0;
    queue_random_ints(36);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
